>>> src/ncm_pkg.sv
// ----------------------------------------------------------------------------
// ncm_pkg
// shared types and constants of the nearest color table match core
// ----------------------------------------------------------------------------
package ncm_pkg;

   localparam int INDEX_BITS   = 4;
   localparam int ENTRIES_BITS = 5;

   // item operations
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // register indexes
   localparam logic CSR_USE_OUTER_LAYER = 1'b0;
   localparam logic CSR_ENTRIES_IN_USE  = 1'b1;

   // control part of the item moving along the cell row
   typedef struct packed {
      logic                  valid;
      logic [INDEX_BITS-1:0] index;
   } ncm_ctl_type;

endpackage

>>> src/ncm_cell.sv
// ----------------------------------------------------------------------------
// ncm_cell
// one table entry plus one stage of the running nearest match search
// ----------------------------------------------------------------------------
module ncm_cell #(
   parameter int CELL_INDEX   = 0,
   parameter int CHANNEL_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  advance,
   input  logic                                  load,
   input  logic [2:0][CHANNEL_BITS-1:0]          load_color,
   input  logic [2:0][CHANNEL_BITS-1:0]          load_outer,
   input  logic [2:0][CHANNEL_BITS-1:0]          load_inner,
   input  logic                                  use_outer_layer,
   input  logic [ncm_pkg::ENTRIES_BITS-1:0]      entries_in_use,
   input  ncm_pkg::ncm_ctl_type                  ctl_in,
   input  logic [2:0][CHANNEL_BITS-1:0]          query_in,
   input  logic [CHANNEL_BITS+1:0]               dist_in,
   input  logic [2:0][CHANNEL_BITS-1:0]          absorb_in,
   output ncm_pkg::ncm_ctl_type                  ctl_out,
   output logic [2:0][CHANNEL_BITS-1:0]          query_out,
   output logic [CHANNEL_BITS+1:0]               dist_out,
   output logic [2:0][CHANNEL_BITS-1:0]          absorb_out
);
   import ncm_pkg::*;

   localparam int  DistBits = CHANNEL_BITS + 2;
   localparam bit  IsFirst  = (CELL_INDEX == 0);

   logic [2:0][CHANNEL_BITS-1:0] ref_ff,    ref_in;
   logic [2:0][CHANNEL_BITS-1:0] outer_ff,  outer_in;
   logic [2:0][CHANNEL_BITS-1:0] inner_ff,  inner_in;
   ncm_ctl_type                  ctl_ff,    ctl_in_next;
   logic [2:0][CHANNEL_BITS-1:0] query_ff,  query_in_next;
   logic [DistBits-1:0]          dist_ff,   dist_in_next;
   logic [2:0][CHANNEL_BITS-1:0] absorb_ff, absorb_in_next;

   logic [2:0][CHANNEL_BITS-1:0] diff;
   logic [DistBits-1:0]          entry_dist;
   logic                         in_use;
   logic                         take;

   // entry storage
   always_comb begin
      ref_in   = load ? load_color : ref_ff;
      outer_in = load ? load_outer : outer_ff;
      inner_in = load ? load_inner : inner_ff;
   end

   // distance of the passing query to this entry
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         diff[c] = (query_in[c] >= ref_ff[c]) ? (query_in[c] - ref_ff[c])
                                              : (ref_ff[c] - query_in[c]);
      end
      entry_dist = {2'b00, diff[0]} + {2'b00, diff[1]} + {2'b00, diff[2]};
   end

   assign in_use = (CELL_INDEX < int'(entries_in_use));
   assign take   = IsFirst || (in_use && (entry_dist < dist_in));

   always_comb begin
      ctl_in_next    = ctl_ff;
      query_in_next  = query_ff;
      dist_in_next   = dist_ff;
      absorb_in_next = absorb_ff;
      if (advance) begin
         ctl_in_next.valid = ctl_in.valid;
         query_in_next     = query_in;
         if (take) begin
            ctl_in_next.index = INDEX_BITS'(CELL_INDEX);
            dist_in_next      = entry_dist;
            absorb_in_next    = use_outer_layer ? outer_ff : inner_ff;
         end else begin
            ctl_in_next.index = ctl_in.index;
            dist_in_next      = dist_in;
            absorb_in_next    = absorb_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      ref_ff    <= ref_in;
      outer_ff  <= outer_in;
      inner_ff  <= inner_in;
      query_ff  <= query_in_next;
      dist_ff   <= dist_in_next;
      absorb_ff <= absorb_in_next;
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in_next;
      end
   end

   assign ctl_out    = ctl_ff;
   assign query_out  = query_ff;
   assign dist_out   = dist_ff;
   assign absorb_out = absorb_ff;

`ifndef SYNTHESIS
   // a stalled row holds its item
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      !advance |=> ($stable(ctl_ff) && $stable(dist_ff)))
      else $error("cell item changed while the row was stalled");

   // a match never gets worse along the row
   a_dist_monotone: assert property (@(posedge clock) disable iff (reset)
      (advance && ctl_in.valid && !IsFirst) |=> (dist_ff <= $past(dist_in)))
      else $error("running distance grew");

   // the first cell always claims the item
   a_first_takes: assert property (@(posedge clock) disable iff (reset)
      (advance && ctl_in.valid && IsFirst) |=> (ctl_ff.index == '0))
      else $error("first cell did not take the item");
`endif

endmodule

>>> src/nearest_color_table_match_core.sv
// ----------------------------------------------------------------------------
// nearest_color_table_match_core
// Each table entry lives in its own cell of a row of TABLE_ENTRIES cells. A
// load item writes one cell in the cycle it is accepted and gives no result. A
// query item enters the first cell at the edge it is accepted and moves one
// cell per cycle while the row is not stalled, each cell comparing its
// entry's L1 distance with the best so far (lower index wins a tie), and
// from the last cell its result is registered in the output register. One
// query is in the row at a time: req_ready is low from the acceptance of a
// query until its result reaches the output register, while loads can follow
// each other back to back. The output register then waits for rsp_ready while
// new items are taken; a result that reaches the end of the row while it is
// still full stalls the row.
// ----------------------------------------------------------------------------
module nearest_color_table_match_core #(
   parameter int TABLE_ENTRIES = 16,
   parameter int CHANNEL_BITS  = 16
) (
   input  logic                               clock,
   input  logic                               reset,

   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_operation,
   input  logic [ncm_pkg::INDEX_BITS-1:0]     req_entry_index,
   input  logic [CHANNEL_BITS-1:0]            req_color_red,
   input  logic [CHANNEL_BITS-1:0]            req_color_green,
   input  logic [CHANNEL_BITS-1:0]            req_color_blue,
   input  logic [CHANNEL_BITS-1:0]            req_outer_red,
   input  logic [CHANNEL_BITS-1:0]            req_outer_green,
   input  logic [CHANNEL_BITS-1:0]            req_outer_blue,
   input  logic [CHANNEL_BITS-1:0]            req_inner_red,
   input  logic [CHANNEL_BITS-1:0]            req_inner_green,
   input  logic [CHANNEL_BITS-1:0]            req_inner_blue,

   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [ncm_pkg::INDEX_BITS-1:0]     rsp_matched_index,
   output logic [CHANNEL_BITS+1:0]            rsp_match_distance,
   output logic [CHANNEL_BITS-1:0]            rsp_absorb_red,
   output logic [CHANNEL_BITS-1:0]            rsp_absorb_green,
   output logic [CHANNEL_BITS-1:0]            rsp_absorb_blue,

   input  logic                               csr_write_enable,
   input  logic                               csr_index,
   input  logic [ncm_pkg::ENTRIES_BITS-1:0]   csr_write_data
);
   import ncm_pkg::*;

   localparam int DistBits = CHANNEL_BITS + 2;

   logic                    use_outer_ff, use_outer_in;
   logic [ENTRIES_BITS-1:0] entries_ff,   entries_in;
   logic                    busy_ff,      busy_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [INDEX_BITS-1:0]   rsp_index_ff, rsp_index_in;
   logic [DistBits-1:0]     rsp_dist_ff,  rsp_dist_in;
   logic [2:0][CHANNEL_BITS-1:0] rsp_absorb_ff, rsp_absorb_in;

   logic accept;
   logic advance;
   logic last_valid;
   logic [2:0][CHANNEL_BITS-1:0] color, outer, inner;

   ncm_ctl_type                  ctl_chain    [TABLE_ENTRIES+1];
   logic [2:0][CHANNEL_BITS-1:0] query_chain  [TABLE_ENTRIES+1];
   logic [DistBits-1:0]          dist_chain   [TABLE_ENTRIES+1];
   logic [2:0][CHANNEL_BITS-1:0] absorb_chain [TABLE_ENTRIES+1];
   logic [TABLE_ENTRIES-1:0]     token_valids;

   assign color = {req_color_blue, req_color_green, req_color_red};
   assign outer = {req_outer_blue, req_outer_green, req_outer_red};
   assign inner = {req_inner_blue, req_inner_green, req_inner_red};

   assign req_ready  = !busy_ff;
   assign accept     = req_valid && req_ready;
   assign last_valid = ctl_chain[TABLE_ENTRIES].valid;
   assign advance    = !(last_valid && rsp_valid_ff && !rsp_ready);

   // configuration registers
   always_comb begin
      use_outer_in = use_outer_ff;
      entries_in   = entries_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_USE_OUTER_LAYER: use_outer_in = csr_write_data[0];
            CSR_ENTRIES_IN_USE:  entries_in   = csr_write_data;
            default:             entries_in   = entries_ff;
         endcase
      end
   end

   // query injection into the first cell
   always_comb begin
      ctl_chain[0].valid = accept && (req_operation == OP_QUERY);
      ctl_chain[0].index = '0;
      query_chain[0]     = color;
      dist_chain[0]      = '0;
      absorb_chain[0]    = '0;
   end

   for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
      logic load;
      assign load = accept && (req_operation == OP_LOAD)
                    && (int'(req_entry_index) == k);
      assign token_valids[k] = ctl_chain[k+1].valid;

      ncm_cell #(
         .CELL_INDEX   (k),
         .CHANNEL_BITS (CHANNEL_BITS)
      ) u_cell (
         .clock           (clock),
         .reset           (reset),
         .advance         (advance),
         .load            (load),
         .load_color      (color),
         .load_outer      (outer),
         .load_inner      (inner),
         .use_outer_layer (use_outer_ff),
         .entries_in_use  (entries_ff),
         .ctl_in          (ctl_chain[k]),
         .query_in        (query_chain[k]),
         .dist_in         (dist_chain[k]),
         .absorb_in       (absorb_chain[k]),
         .ctl_out         (ctl_chain[k+1]),
         .query_out       (query_chain[k+1]),
         .dist_out        (dist_chain[k+1]),
         .absorb_out      (absorb_chain[k+1])
      );
   end

   // busy from query acceptance until its result leaves the row
   always_comb begin
      busy_in = busy_ff;
      if (accept && (req_operation == OP_QUERY)) begin
         busy_in = 1'b1;
      end else if (last_valid && advance) begin
         busy_in = 1'b0;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_dist_in   = rsp_dist_ff;
      rsp_absorb_in = rsp_absorb_ff;
      if (last_valid && advance) begin
         rsp_valid_in  = 1'b1;
         rsp_index_in  = ctl_chain[TABLE_ENTRIES].index;
         rsp_dist_in   = dist_chain[TABLE_ENTRIES];
         rsp_absorb_in = absorb_chain[TABLE_ENTRIES];
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rsp_index_ff  <= rsp_index_in;
      rsp_dist_ff   <= rsp_dist_in;
      rsp_absorb_ff <= rsp_absorb_in;
      if (reset) begin
         use_outer_ff <= 1'b0;
         entries_ff   <= ENTRIES_BITS'(1);
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         use_outer_ff <= use_outer_in;
         entries_ff   <= entries_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_matched_index  = rsp_index_ff;
   assign rsp_match_distance = rsp_dist_ff;
   assign rsp_absorb_red     = rsp_absorb_ff[0];
   assign rsp_absorb_green   = rsp_absorb_ff[1];
   assign rsp_absorb_blue    = rsp_absorb_ff[2];

`ifndef SYNTHESIS
   a_single_item: assert property (@(posedge clock) disable iff (reset)
      $countones(token_valids) <= 1)
      else $error("more than one item in the cell row");

   a_item_needs_busy: assert property (@(posedge clock) disable iff (reset)
      (|token_valids) |-> busy_ff)
      else $error("item in the cell row while not busy");

   a_result_ends_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $fell(busy_ff))
      else $error("result appeared without leaving the row");

   a_query_enters: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_operation == OP_QUERY)) |=> token_valids[0])
      else $error("accepted item did not enter the first cell");
`endif

endmodule
